### rtl/gf2_128_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// GF(2^128) exponentiation assertion macros
// Shared concurrent assertion forms for the exponentiation block.
// ----------------------------------------------------------------------------
`ifndef GF2_128_EXPONENTIATION_MACROS_SVH
`define GF2_128_EXPONENTIATION_MACROS_SVH

// same-cycle implication
`define GFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gfe_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^128) exponentiation package
// Widths, field constants, sequencer states and multiplier interface types.
// ----------------------------------------------------------------------------
package gfe_pkg;

	localparam int GF_W       = 128;
	localparam int HALF_W     = 64;
	localparam int POLY_W     = 8;
	localparam logic [POLY_W-1:0] GF_POLY = 8'h87;

	// multiplier bits consumed per cycle
	localparam int DIGIT_W    = 8;
	localparam int MUL_STEPS  = GF_W / DIGIT_W;
	localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
	localparam int BIT_CNT_W  = $clog2(GF_W);

	localparam int IN_DATA_W  = 2 * GF_W;
	localparam int OUT_DATA_W = GF_W;

	typedef logic [GF_W-1:0] gf_elem_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQR,
		ST_MUL,
		ST_DONE
	} gfe_state_t;

	typedef struct packed {
		logic     start;
		gf_elem_t a;
		gf_elem_t b;
	} mul_req_t;

	typedef struct packed {
		logic     busy;
		logic     done;
		gf_elem_t product;
	} mul_rsp_t;

endpackage

### rtl/gf2_128_exponentiation.sv
// ----------------------------------------------------------------------------
// GF(2^128) exponentiation
// base^exponent by left-to-right square-and-multiply on one shared multiplier.
// ----------------------------------------------------------------------------
// Input word on s_axis: base (128 bits) and exponent (128 bits). Output word
// on m_axis: the power, 128 bits. A zero exponent gives the element 1.
// One word is worked on at a time; s_axis_tready is high only while idle.
// The exponent is scanned MSB first, one bit per step. Leading zero bits
// take one scan step each and the top set bit loads the base directly;
// every later bit costs a square, or a square and a multiply, on the
// digit-serial multiplier (8 bits a cycle), each with issue and hand-back.
// The result sits in an output register: a new word is accepted while it
// waits, and a finished power waits in the sequencer while m_axis_tready
// is low and the output register is still full.
// Reset (arst_n low) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
`include "gf2_128_exponentiation_macros.svh"

module gf2_128_exponentiation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// base_lo, base_hi, exponent_lo, exponent_hi
	input  logic [gfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// power_lo, power_hi
	output logic [gfe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import gfe_pkg::*;

	gfe_state_t           state_q;
	gfe_state_t           state_d;
	gf_elem_t             base_q;
	gf_elem_t             exp_q;
	gf_elem_t             power_q;
	gf_elem_t             out_q;
	logic [BIT_CNT_W-1:0] bitcnt_q;
	logic                 started_q;
	logic                 out_valid_q;

	mul_req_t             mul_req;
	mul_rsp_t             mul_rsp;

	logic                 in_fire;
	logic                 bit_now;
	logic                 last_bit;
	logic                 advance;
	logic                 take_base;
	logic                 load_power;
	logic                 load_out;

	gfe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign bit_now       = exp_q[GF_W-1];
	assign last_bit      = (bitcnt_q == BIT_CNT_W'(GF_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = power_q;
		mul_req.b     = power_q;
		advance       = 1'b0;
		take_base     = 1'b0;
		load_power    = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (started_q) begin
					mul_req.start = 1'b1;
					state_d       = ST_SQR;
				end else begin
					// power is still 1: squaring is a no-op, multiply is a copy
					take_base = bit_now;
					advance   = 1'b1;
					state_d   = last_bit ? ST_DONE : ST_SCAN;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					load_power = 1'b1;
					if (bit_now) begin
						mul_req.start = 1'b1;
						mul_req.a     = mul_rsp.product;
						mul_req.b     = base_q;
						state_d       = ST_MUL;
					end else begin
						advance = 1'b1;
						state_d = last_bit ? ST_DONE : ST_SCAN;
					end
				end
			end
			ST_MUL: begin
				if (mul_rsp.done) begin
					load_power = 1'b1;
					advance    = 1'b1;
					state_d    = last_bit ? ST_DONE : ST_SCAN;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q    <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				bitcnt_q  <= '0;
				started_q <= 1'b0;
			end else begin
				if (advance) begin
					bitcnt_q <= bitcnt_q + 1'b1;
				end
				if (take_base) begin
					started_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q  <= s_axis_tdata[GF_W-1:0];
			exp_q   <= s_axis_tdata[IN_DATA_W-1:GF_W];
			power_q <= gf_elem_t'(1);
		end else begin
			if (take_base) begin
				power_q <= base_q;
			end else if (load_power) begin
				power_q <= mul_rsp.product;
			end
			if (advance) begin
				exp_q <= exp_q << 1;
			end
		end
		if (load_out) begin
			out_q <= power_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`GFE_ASSERT_NOW(a_done_in_mul_state, clk, arst_n, mul_rsp.done,
		(state_q == ST_SQR || state_q == ST_MUL), "multiplier done outside a multiply step")
	`GFE_ASSERT_NOW(a_start_when_free, clk, arst_n, mul_req.start, !mul_rsp.busy,
		"multiplier started while busy")
	`GFE_ASSERT_NEXT(a_accept_restarts, clk, arst_n, in_fire,
		(state_q == ST_SCAN && !started_q && bitcnt_q == '0), "accept did not restart the scan")

endmodule

### rtl/gfe_mul.sv
// ----------------------------------------------------------------------------
// GF(2^128) digit-serial multiplier
// Shift-and-add product mod x^128+x^7+x^2+x+1, DIGIT_W multiplier bits a cycle,
// least significant first. done pulses one cycle with the product held.
// ----------------------------------------------------------------------------
module gfe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  gfe_pkg::mul_req_t req,
	output gfe_pkg::mul_rsp_t rsp
);
	import gfe_pkg::*;

	function automatic gf_elem_t times_x(input gf_elem_t v);
		gf_elem_t r;
		r = {v[GF_W-2:0], 1'b0};
		if (v[GF_W-1]) begin
			r[POLY_W-1:0] = r[POLY_W-1:0] ^ GF_POLY;
		end
		return r;
	endfunction

	gf_elem_t             acc_q;
	gf_elem_t             run_q;
	gf_elem_t             mult_q;
	gf_elem_t             acc_d;
	gf_elem_t             run_d;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 last_step;

	assign last_step = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));

	always_comb begin
		acc_d = acc_q;
		run_d = run_q;
		for (int k = 0; k < DIGIT_W; k++) begin
			if (mult_q[k]) begin
				acc_d = acc_d ^ run_d;
			end
			run_d = times_x(run_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			run_q  <= req.a;
			mult_q <= req.b;
		end else if (busy_q) begin
			acc_q  <= acc_d;
			run_q  <= run_d;
			mult_q <= mult_q >> DIGIT_W;
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
